FILE: rtl/core/rsi_pkg.sv
// ----------------------------------------------------------------------------
// Ray-sphere intersection package
// Shared widths and the record that travels beside the square-root pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // width of the quarter discriminant taken as unsigned (after the sign test)
  localparam int unsigned RAD_W   = 75;
  // bits of the integer square root, one per pipeline stage
  localparam int unsigned ROOT_W  = 38;
  // width of the trial subtrahend inside one root stage
  localparam int unsigned TRIAL_W = 80;
  // half of b, Q16.16 after the direction fraction is dropped
  localparam int unsigned H_W     = 37;

  typedef struct packed {
    logic [H_W-1:0]   h;
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic             neg;
  } rsi_carry_t;

endpackage

FILE: rtl/core/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor root of an unsigned radicand, one result bit per register stage, with
// a side record that moves in step with each stage.
// ----------------------------------------------------------------------------
module rsi_sqrt import rsi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  radicand_i,
  input  rsi_carry_t        carry_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output rsi_carry_t        carry_o
);

  logic [RAD_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic              vld_q  [ROOT_W];
  rsi_carry_t        car_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int unsigned B = ROOT_W - 1 - k;
    logic [RAD_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic               v_in;
    rsi_carry_t         c_in;
    logic [TRIAL_W-1:0] trial;
    logic               take;

    if (k == 0) begin : g_first
      assign rem_in  = radicand_i;
      assign root_in = '0;
      assign v_in    = valid_i;
      assign c_in    = carry_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = vld_q[k-1];
      assign c_in    = car_q[k-1];
    end

    // (2*root + 2^B) * 2^B, the growth of root^2 when bit B is set
    assign trial = ({{(TRIAL_W-ROOT_W){1'b0}}, root_in} << (B + 1))
                 | ({{(TRIAL_W-1){1'b0}}, 1'b1} << (2 * B));
    assign take  = {{(TRIAL_W-RAD_W){1'b0}}, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        car_q[k] <= c_in;
        if (take) begin
          rem_q[k]  <= rem_in - trial[RAD_W-1:0];
          root_q[k] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign carry_o = car_q[ROOT_W-1];

endmodule

FILE: rtl/core/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// Ray-sphere intersection
// Streams rays against one configured sphere and reports the near hit.
// ----------------------------------------------------------------------------
// Rays enter on the in_valid_i / in_ready_o channel, one transfer per ray;
// results leave on out_valid_o / out_ready_i, one transfer per ray, in order.
// The sphere centre and radius are set through the write port (index 0..2:
// centre x/y/z, 3: radius); write them only while no ray is in flight.
// Throughput is one ray per cycle while the receiver takes results. Five
// stages form the offset, dot products and discriminant, the 38-stage
// bit-per-stage square root follows, then three stages for distance, hit
// point and normal. The square-root chain sets the depth.
// On a miss the hit flag and every other field read zero.
// Reset empties the pipeline and loads centre 0 and radius 1.0.
// When the receiver stalls the whole pipeline holds in place and in_ready_o
// falls; nothing is dropped or repeated, and it refills at full rate.
// ----------------------------------------------------------------------------
module ray_sphere_intersect import rsi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [30:0]        distance_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic signed [31:0] normal_x_o,
  output logic signed [31:0] normal_y_o,
  output logic signed [31:0] normal_z_o
);

  localparam logic [2:0] REG_CX  = 3'd0;
  localparam logic [2:0] REG_CY  = 3'd1;
  localparam logic [2:0] REG_CZ  = 3'd2;
  localparam logic [2:0] REG_RAD = 3'd3;

  function automatic logic [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sh0_7FFF_FFFF)       return 32'h7FFF_FFFF;
    else if (v < -43'sh0_8000_0000) return 32'h8000_0000;
    else                            return v[31:0];
  endfunction

  // configuration
  logic [2:0][31:0] cen_q;
  logic [30:0]      rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q <= '0;
      rad_q <= 31'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CX:  cen_q[0] <= cfg_data_i;
        REG_CY:  cen_q[1] <= cfg_data_i;
        REG_CZ:  cen_q[2] <= cfg_data_i;
        REG_RAD: rad_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: offset from centre
  logic              v1_q;
  logic [2:0][31:0]  org1_q, dir1_q;
  logic [2:0][32:0]  oc1_q;

  // stage 2: products
  logic              v2_q;
  logic [2:0][31:0]  org2_q, dir2_q;
  logic [2:0][64:0]  p2_q;
  logic [2:0][65:0]  q2_q;
  logic [61:0]       rr2_q;

  // stage 3: sums, h
  logic              v3_q;
  logic [2:0][31:0]  org3_q, dir3_q;
  logic signed [H_W-1:0] h3_q;
  logic signed [67:0] qs3_q;
  logic [61:0]       rr3_q;

  // stage 4: h squared
  logic              v4_q;
  logic [2:0][31:0]  org4_q, dir4_q;
  logic signed [H_W-1:0] h4_q;
  logic signed [73:0] hh4_q;
  logic signed [67:0] qs4_q;
  logic [61:0]       rr4_q;

  // stage 5: discriminant
  logic              v5_q;
  logic signed [75:0] d5_q;
  rsi_carry_t        c5_q;

  logic signed [66:0] dot3_d;
  logic signed [67:0] qs3_d;
  logic signed [75:0] d5_d;

  always_comb begin
    dot3_d = $signed(p2_q[0]) + $signed(p2_q[1]) + $signed(p2_q[2]);
    qs3_d  = $signed(q2_q[0]) + $signed(q2_q[1]) + $signed(q2_q[2]);
    d5_d   = hh4_q + $signed({1'b0, rr4_q}) - qs4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      org1_q <= {origin_z_i, origin_y_i, origin_x_i};
      dir1_q <= {dir_z_i, dir_y_i, dir_x_i};
      oc1_q[0] <= 33'($signed(origin_x_i) - $signed(cen_q[0]));
      oc1_q[1] <= 33'($signed(origin_y_i) - $signed(cen_q[1]));
      oc1_q[2] <= 33'($signed(origin_z_i) - $signed(cen_q[2]));

      org2_q <= org1_q;
      dir2_q <= dir1_q;
      for (int i = 0; i < 3; i++) begin
        p2_q[i] <= 65'($signed(dir1_q[i]) * $signed(oc1_q[i]));
        q2_q[i] <= 66'($signed(oc1_q[i]) * $signed(oc1_q[i]));
      end
      rr2_q <= rad_q * rad_q;

      org3_q <= org2_q;
      dir3_q <= dir2_q;
      h3_q   <= dot3_d[66:30];
      qs3_q  <= qs3_d;
      rr3_q  <= rr2_q;

      org4_q <= org3_q;
      dir4_q <= dir3_q;
      h4_q   <= h3_q;
      hh4_q  <= 74'(h3_q * h3_q);
      qs4_q  <= qs3_q;
      rr4_q  <= rr3_q;

      d5_q      <= d5_d;
      c5_q.h    <= h4_q;
      c5_q.org  <= org4_q;
      c5_q.dir  <= dir4_q;
      c5_q.neg  <= d5_d[75];
    end
  end

  // square root
  logic              vs;
  logic [ROOT_W-1:0] root_s;
  rsi_carry_t        cs;

  rsi_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v5_q),
    .radicand_i (d5_q[RAD_W-1:0]),
    .carry_i    (c5_q),
    .valid_o    (vs),
    .root_o     (root_s),
    .carry_o    (cs)
  );

  // stage T: near root
  logic              vt_q, okt_q;
  logic signed [38:0] tt_q;
  logic [2:0][31:0]  orgt_q, dirt_q;
  logic signed [38:0] t_d;

  // stage M: direction times distance
  logic              vm_q, okm_q;
  logic signed [38:0] tm_q;
  logic [2:0][31:0]  orgm_q;
  logic [2:0][70:0]  mm_q;

  assign t_d = -$signed({{2{cs.h[H_W-1]}}, cs.h}) - $signed({1'b0, root_s});

  // output stage
  logic signed [42:0] pt_d  [3];
  logic signed [42:0] nrm_d [3];
  logic [30:0]        dist_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt_d[i]  = 43'($signed(orgm_q[i])) + 43'($signed(mm_q[i][70:30]));
      nrm_d[i] = pt_d[i] - 43'($signed(cen_q[i]));
    end
    if (tm_q[38:31] != 8'd0) dist_d = 31'h7FFF_FFFF;
    else                      dist_d = tm_q[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q        <= 1'b0;
      vm_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      vt_q        <= vs;
      vm_q        <= vt_q;
      out_valid_o <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tt_q   <= t_d;
      okt_q  <= !cs.neg && (t_d > 39'sd0);
      orgt_q <= cs.org;
      dirt_q <= cs.dir;

      tm_q   <= tt_q;
      okm_q  <= okt_q;
      orgm_q <= orgt_q;
      for (int i = 0; i < 3; i++) begin
        mm_q[i] <= 71'($signed(dirt_q[i]) * tt_q);
      end

      // zero every field on a miss
      hit_o      <= okm_q;
      distance_o <= okm_q ? dist_d : '0;
      point_x_o  <= okm_q ? sat32(pt_d[0])  : '0;
      point_y_o  <= okm_q ? sat32(pt_d[1])  : '0;
      point_z_o  <= okm_q ? sat32(pt_d[2])  : '0;
      normal_x_o <= okm_q ? sat32(nrm_d[0]) : '0;
      normal_y_o <= okm_q ? sat32(nrm_d[1]) : '0;
      normal_z_o <= okm_q ? sat32(nrm_d[2]) : '0;
    end
  end

endmodule
